// ===== rtl/core/spirv_module_checker_macros.svh =====
// ============================================================================
// SPIR-V module checker assertion macros
// Shared property wrappers, clocked on i_clk with i_rst_n as disable
// ============================================================================
`ifndef SPIRV_MODULE_CHECKER_MACROS_SVH
`define SPIRV_MODULE_CHECKER_MACROS_SVH

// same-cycle implication
`define SCM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SCM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/scm_pkg.sv =====
// ============================================================================
// scm_pkg
// Types and constants shared by the SPIR-V module checker
// ============================================================================
package scm_pkg;

    localparam logic [31:0] SPV_MAGIC        = 32'h0723_0203;
    localparam logic [15:0] OP_ENTRY_POINT   = 16'd15;
    localparam logic [31:0] MODEL_GL_COMPUTE = 32'd5;
    localparam int          MIN_MODULE_WORDS = 5;
    localparam logic [5:0]  MAX_NAME_BYTES   = 6'd32;
    localparam logic [15:0] MIN_ENTRY_WORDS  = 16'd3;
    localparam int          NAME_BITS        = 256;

    // check result codes, also used for the latched error (ok means none)
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_STRUCT   = 2'd1,
        ST_VERSION  = 2'd2,
        ST_NO_ENTRY = 2'd3
    } t_status;

    // register indexes on the configuration port
    typedef enum logic [2:0] {
        REG_MAX_MINOR = 3'd0,
        REG_NAME_LEN  = 3'd1,
        REG_NAME_B0   = 3'd2,
        REG_NAME_B1   = 3'd3,
        REG_NAME_B2   = 3'd4,
        REG_NAME_B3   = 3'd5
    } t_reg_idx;

    // configuration as seen by the checking logic
    typedef struct packed {
        logic [7:0]           max_minor;
        logic [5:0]           name_len;   // already clamped to MAX_NAME_BYTES
        logic [NAME_BITS-1:0] name;
    } t_cfg;

    // entry point name comparison state
    typedef struct packed {
        logic       mismatch;
        logic       ended;
        logic [5:0] pos;
    } t_name_upd;

endpackage

// ===== rtl/core/scm_cfg_regs.sv =====
// ============================================================================
// scm_cfg_regs
// APB register file holding version limit and wanted entry point name
// ============================================================================
module scm_cfg_regs (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [5:0]          paddr,
    input  logic [63:0]         pwdata,
    output logic [63:0]         prdata,
    output logic                pready,
    output scm_pkg::t_cfg       o_cfg
);

    logic [7:0]      r_max_minor;
    logic [5:0]      r_name_len;
    logic [63:0]     r_name [4];
    logic            wr_en;
    scm_pkg::t_reg_idx reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = scm_pkg::t_reg_idx'(paddr[5:3]);

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_minor <= 8'd6;
            r_name_len  <= 6'd4;
            r_name[0]   <= 64'd1852399981;
            r_name[1]   <= '0;
            r_name[2]   <= '0;
            r_name[3]   <= '0;
        end else if (wr_en) begin
            unique case (reg_idx)
                scm_pkg::REG_MAX_MINOR: r_max_minor <= pwdata[7:0];
                scm_pkg::REG_NAME_LEN:  r_name_len  <= pwdata[5:0];
                scm_pkg::REG_NAME_B0:   r_name[0]   <= pwdata;
                scm_pkg::REG_NAME_B1:   r_name[1]   <= pwdata;
                scm_pkg::REG_NAME_B2:   r_name[2]   <= pwdata;
                scm_pkg::REG_NAME_B3:   r_name[3]   <= pwdata;
                default: ;
            endcase
        end
    end

    // read back
    always_comb begin
        unique case (reg_idx)
            scm_pkg::REG_MAX_MINOR: prdata = {56'd0, r_max_minor};
            scm_pkg::REG_NAME_LEN:  prdata = {58'd0, r_name_len};
            scm_pkg::REG_NAME_B0:   prdata = r_name[0];
            scm_pkg::REG_NAME_B1:   prdata = r_name[1];
            scm_pkg::REG_NAME_B2:   prdata = r_name[2];
            scm_pkg::REG_NAME_B3:   prdata = r_name[3];
            default:                prdata = '0;
        endcase
    end

    // name length above the name store size counts as the full store
    assign o_cfg.max_minor = r_max_minor;
    assign o_cfg.name_len  = (r_name_len > scm_pkg::MAX_NAME_BYTES) ?
                             scm_pkg::MAX_NAME_BYTES : r_name_len;
    assign o_cfg.name      = {r_name[3], r_name[2], r_name[1], r_name[0]};

endmodule

// ===== rtl/core/scm_name_match.sv =====
// ============================================================================
// scm_name_match
// Compares the four name bytes of one word against the wanted name
// ============================================================================
module scm_name_match (
    input  logic [31:0]          i_word,
    input  scm_pkg::t_name_upd   i_state,
    input  scm_pkg::t_cfg        i_cfg,
    output scm_pkg::t_name_upd   o_next
);

    logic [7:0] b;
    logic [6:0] idx;
    logic [6:0] sum;
    logic [2:0] cnt;
    logic       ended;
    logic       mism;

    // bytes in order, up to the first nul
    always_comb begin
        ended = i_state.ended;
        mism  = i_state.mismatch;
        cnt   = '0;
        b     = '0;
        idx   = '0;
        for (int k = 0; k < 4; k++) begin
            b = i_word[8*k +: 8];
            if (!ended) begin
                if (b == 8'd0) begin
                    ended = 1'b1;
                end else begin
                    idx = {1'b0, i_state.pos} + {4'd0, cnt};
                    if (idx >= {1'b0, i_cfg.name_len} ||
                        i_cfg.name[{idx[4:0], 3'b000} +: 8] != b) begin
                        mism = 1'b1;
                    end
                    cnt = cnt + 3'd1;
                end
            end
        end
    end

    // byte position saturates at 63
    assign sum             = {1'b0, i_state.pos} + {4'd0, cnt};
    assign o_next.mismatch = mism;
    assign o_next.ended    = ended;
    assign o_next.pos      = sum[6] ? 6'd63 : sum[5:0];

endmodule

// ===== rtl/core/scm_walker.sv =====
// ============================================================================
// scm_walker
// Per-word header, version and instruction walk; gives status on last word
// ============================================================================
`include "spirv_module_checker_macros.svh"

module scm_walker #(
    parameter int MAX_MODULE_WORDS = 67108864
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [31:0]       i_word,
    input  logic              i_last,
    input  logic [2:0]        i_vbytes,
    input  scm_pkg::t_cfg     i_cfg,
    output logic              o_result_valid,
    output logic [1:0]        o_status
);

    localparam int PosW = $clog2(MAX_MODULE_WORDS + 1);
    localparam logic [PosW-1:0] MaxWords = PosW'(MAX_MODULE_WORDS);
    localparam logic [PosW-1:0] PosOne   = PosW'(1);
    localparam logic [PosW-1:0] PosMin   = PosW'(scm_pkg::MIN_MODULE_WORDS);

    logic [PosW-1:0]     r_word_pos,   n_word_pos;
    logic [15:0]         r_words_left, n_words_left;
    logic [15:0]         r_instr_off,  n_instr_off;
    logic                r_cand,       n_cand;
    logic                r_model_cs,   n_model_cs;
    scm_pkg::t_name_upd  r_name,       n_name;
    logic                r_found,      n_found;
    scm_pkg::t_status    r_latched,    n_latched;
    logic                r_size_err,   n_size_err;
    scm_pkg::t_name_upd  name_next;
    scm_pkg::t_status    status;

    scm_name_match u_name_match (
        .i_word  (i_word),
        .i_state (r_name),
        .i_cfg   (i_cfg),
        .o_next  (name_next)
    );

    // next stream state and status
    always_comb begin
        n_word_pos   = r_word_pos;
        n_words_left = r_words_left;
        n_instr_off  = r_instr_off;
        n_cand       = r_cand;
        n_model_cs   = r_model_cs;
        n_name       = r_name;
        n_found      = r_found;
        n_latched    = r_latched;
        n_size_err   = r_size_err;
        status       = scm_pkg::ST_OK;
        if (i_step) begin
            if (i_vbytes != 3'd4) begin
                n_size_err = 1'b1;
            end
            if (r_word_pos >= MaxWords) begin
                n_size_err = 1'b1;
            end else begin
                if (r_latched == scm_pkg::ST_OK) begin
                    if (r_word_pos == '0) begin
                        // magic number
                        if (i_word != scm_pkg::SPV_MAGIC) begin
                            n_latched = scm_pkg::ST_STRUCT;
                        end
                    end else if (r_word_pos == PosOne) begin
                        // version word
                        if (i_word[23:16] != 8'd1 || i_word[15:8] > i_cfg.max_minor) begin
                            n_latched = scm_pkg::ST_VERSION;
                        end
                    end else if (r_word_pos >= PosMin) begin
                        if (r_words_left == '0) begin
                            // first word of an instruction
                            if (i_word[31:16] == 16'd0) begin
                                n_latched = scm_pkg::ST_STRUCT;
                            end else begin
                                n_words_left = i_word[31:16] - 16'd1;
                                n_instr_off  = '0;
                                n_cand       = (i_word[15:0] == scm_pkg::OP_ENTRY_POINT) &&
                                               (i_word[31:16] >= scm_pkg::MIN_ENTRY_WORDS);
                                n_model_cs   = 1'b0;
                                n_name       = '0;
                            end
                        end else begin
                            // operand word
                            n_instr_off = r_instr_off + 16'd1;
                            if (r_cand) begin
                                if (n_instr_off == 16'd1) begin
                                    n_model_cs = (i_word == scm_pkg::MODEL_GL_COMPUTE);
                                end else if (n_instr_off >= 16'd3) begin
                                    n_name = name_next;
                                end
                            end
                            n_words_left = r_words_left - 16'd1;
                            if (n_words_left == '0 && r_cand && n_model_cs &&
                                !n_name.mismatch && n_name.pos == i_cfg.name_len) begin
                                n_found = 1'b1;
                            end
                        end
                    end
                end
                n_word_pos = r_word_pos + PosW'(1);
            end
            if (i_last) begin
                // size or length error first, then latched error, overrun, entry
                if (n_size_err || n_word_pos < PosMin) begin
                    status = scm_pkg::ST_STRUCT;
                end else if (n_latched != scm_pkg::ST_OK) begin
                    status = n_latched;
                end else if (n_words_left != '0) begin
                    status = scm_pkg::ST_STRUCT;
                end else if (n_found) begin
                    status = scm_pkg::ST_OK;
                end else begin
                    status = scm_pkg::ST_NO_ENTRY;
                end
                // back to the start for the next module
                n_word_pos   = '0;
                n_words_left = '0;
                n_instr_off  = '0;
                n_cand       = 1'b0;
                n_model_cs   = 1'b0;
                n_name       = '0;
                n_found      = 1'b0;
                n_latched    = scm_pkg::ST_OK;
                n_size_err   = 1'b0;
            end
        end
    end

    assign o_result_valid = i_step && i_last;
    assign o_status       = status;

    // stream state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_pos   <= '0;
            r_words_left <= '0;
            r_instr_off  <= '0;
            r_cand       <= 1'b0;
            r_model_cs   <= 1'b0;
            r_name       <= '0;
            r_found      <= 1'b0;
            r_latched    <= scm_pkg::ST_OK;
            r_size_err   <= 1'b0;
        end else begin
            r_word_pos   <= n_word_pos;
            r_words_left <= n_words_left;
            r_instr_off  <= n_instr_off;
            r_cand       <= n_cand;
            r_model_cs   <= n_model_cs;
            r_name       <= n_name;
            r_found      <= n_found;
            r_latched    <= n_latched;
            r_size_err   <= n_size_err;
        end
    end

    // first latched error is kept until the module ends
    `SCM_ASSERT_NEXT(a_error_sticky, r_latched != scm_pkg::ST_OK && !(i_step && i_last), r_latched == $past(r_latched), "latched error changed inside a module")
    // last word returns the walk to its start
    `SCM_ASSERT_NEXT(a_clear_on_last, i_step && i_last, r_word_pos == '0 && r_words_left == '0 && !r_found, "stream state not cleared after last word")
    // an instruction is only open once the header is past
    `SCM_ASSERT_NOW(a_walk_after_header, r_words_left != '0, r_word_pos > PosMin, "instruction open inside the header")

endmodule

// ===== rtl/core/spirv_module_checker.sv =====
// A word accepted into the input register is checked by the walker when the pipeline
// advances; the status for the last word is then registered in the result register.
// Throughput: one word per cycle, set by the single-pass walker between the input
// and result registers; stalls only while a held status is not taken.
// Reset (synchronous, active low) clears the stream state and loads register defaults.
// ============================================================================
// spirv_module_checker
// SPIR-V module header, version, structure and entry point checker
// ============================================================================
`include "spirv_module_checker_macros.svh"

module spirv_module_checker #(
    parameter int MAX_MODULE_WORDS = 67108864
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // word stream
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [31:0]  s_axis_tdata,   // [31:0] data_word
    input  logic         s_axis_tlast,   // final_word
    input  logic [2:0]   s_axis_tuser,   // [2:0] valid_bytes
    // status stream
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [7:0]   m_axis_tdata,   // [1:0] check_status, [7:2] zero
    // configuration
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [5:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready
);

    logic          r_in_valid;
    logic [31:0]   r_in_word;
    logic          r_in_last;
    logic [2:0]    r_in_vbytes;
    logic          r_out_valid;
    logic [1:0]    r_out_status;
    logic          advance;
    logic          step;
    logic          in_take;
    logic          res_valid;
    logic [1:0]    res_status;
    scm_pkg::t_cfg cfg;

    scm_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // pipeline moves when the result register is free or being emptied
    assign advance       = !r_out_valid || m_axis_tready;
    assign step          = r_in_valid && advance;
    assign s_axis_tready = !r_in_valid || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    scm_walker #(
        .MAX_MODULE_WORDS (MAX_MODULE_WORDS)
    ) u_walker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (step),
        .i_word         (r_in_word),
        .i_last         (r_in_last),
        .i_vbytes       (r_in_vbytes),
        .i_cfg          (cfg),
        .o_result_valid (res_valid),
        .o_status       (res_status)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_word   <= s_axis_tdata;
            r_in_last   <= s_axis_tlast;
            r_in_vbytes <= s_axis_tuser;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && res_valid) begin
            r_out_status <= res_status;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_out_status};

    // input side only stalls with both stages full
    `SCM_ASSERT_NOW(a_stall_cause, !s_axis_tready, r_in_valid && r_out_valid,
        "input stalled without a full pipeline")
    // a new status only comes from a last word
    `SCM_ASSERT_NOW(a_status_from_last, $rose(r_out_valid),
        $past(r_in_valid && r_in_last), "status produced without a last word")

endmodule
